@@ src/integer_to_radix_digits_macros.svh @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits assertion macros
// Shared property macros, sampled on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

// Same-cycle implication.
`define I2R_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2r: same-cycle property failed");

// Next-cycle implication.
`define I2R_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2r: next-cycle property failed");

`endif

@@ src/i2r_pkg.sv @@
// ----------------------------------------------------------------------------
// i2r_pkg
// Types and constants shared by the radix digit converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

   localparam int RADIX_W = 4;
   localparam int DIGIT_W = 4;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 4'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SKIP = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   typedef struct packed {
      logic start;   // load a new value and begin the conversion pass
      logic shift;   // move every digit one place toward the top
   } ctl_type;

   typedef struct packed {
      logic               done;   // conversion pass finished, digits final
      logic [DIGIT_W-1:0] top;    // most significant digit slot
   } sts_type;

endpackage

@@ src/i2r_if.sv @@
// ----------------------------------------------------------------------------
// i2r channel interfaces
// Valid/ready channels for the input values and the output digits.
// ----------------------------------------------------------------------------
interface i2r_req_if
   import i2r_pkg::*;
#(
   parameter int VALUE_BITS = 31
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic [RADIX_W-1:0]    radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface i2r_rsp_if
   import i2r_pkg::*;
;
   logic               valid;
   logic               ready;
   logic [DIGIT_W-1:0] digit;
   logic               last;

   modport source (output valid, output digit, output last, input ready);
   modport sink   (input valid, input digit, input last, output ready);
endinterface

@@ src/i2r_conv.sv @@
// ----------------------------------------------------------------------------
// i2r_conv
// Systolic row of radix digit cells fed one value bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module i2r_conv
   import i2r_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [RADIX_W-1:0]    radix,
   output sts_type               sts
);

   // radix two needs one cell per value bit
   localparam int NCELL = VALUE_BITS;
   localparam int CNT_W = $clog2(2 * VALUE_BITS);
   localparam logic [CNT_W-1:0] CNT_FEED = CNT_W'(VALUE_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * VALUE_BITS - 2);

   logic [VALUE_BITS-1:0] value_sr_ff;
   logic [RADIX_W-1:0]    radix_ff;
   logic [RADIX_W-1:0]    radix_sat;
   logic [NCELL-1:1]      en_ff;
   logic [NCELL-2:0]      cry_ff;
   logic [DIGIT_W-1:0]    digit_ff [NCELL];
   logic [DIGIT_W-1:0]    digit_in [NCELL];
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic                  feed;
   logic [NCELL-1:0]      act;
   logic [NCELL-1:0]      cin;
   logic [NCELL-1:0]      cout;
   logic [DIGIT_W:0]      twice;

   always_comb begin
      if (radix < RADIX_MIN) begin
         radix_sat = RADIX_MIN;
      end else if (radix > RADIX_MAX) begin
         radix_sat = RADIX_MAX;
      end else begin
         radix_sat = radix;
      end
   end

   // cell i works behind cell i-1 through the en_ff and cry_ff registers, on the carries of cell i-1
   assign feed = busy_ff && (cnt_ff < CNT_FEED);
   assign act  = {en_ff, feed};
   assign cin  = {cry_ff, value_sr_ff[VALUE_BITS-1]};

   always_comb begin
      twice = '0;
      for (int i = 0; i < NCELL; i++) begin
         twice   = {digit_ff[i], cin[i]};
         cout[i] = (twice >= {1'b0, radix_ff});
         if (!act[i]) begin
            digit_in[i] = digit_ff[i];
         end else if (cout[i]) begin
            digit_in[i] = DIGIT_W'(twice - {1'b0, radix_ff});
         end else begin
            digit_in[i] = twice[DIGIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         en_ff   <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CNT_LAST);
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            en_ff   <= '0;
         end else begin
            en_ff <= act[NCELL-2:0];
            if (busy_ff) begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  busy_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         value_sr_ff <= value;
         radix_ff    <= radix_sat;
         for (int i = 0; i < NCELL; i++) begin
            digit_ff[i] <= '0;
         end
      end else if (ctl.shift) begin
         digit_ff[0] <= '0;
         for (int i = 1; i < NCELL; i++) begin
            digit_ff[i] <= digit_ff[i-1];
         end
      end else begin
         if (feed) begin
            value_sr_ff <= {value_sr_ff[VALUE_BITS-2:0], 1'b0};
         end
         for (int i = 0; i < NCELL; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
      cry_ff <= cout[NCELL-2:0];
   end

   assign sts.done = done_ff;
   assign sts.top  = digit_ff[NCELL-1];

endmodule

@@ src/integer_to_radix_digits.sv @@
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts an unsigned integer into its digits in a radix from two to ten.
// ----------------------------------------------------------------------------
// req_ch carries value and radix; a transaction completes when valid and
// ready are high at a rising clock edge. rsp_ch returns one transaction per
// digit, most significant first, with no leading zeros; last marks the least
// significant digit. A zero value gives the single digit 0. Radix codes below
// two act as two, codes above ten act as ten.
// The block holds one value at a time: req_ch.ready is high only while idle.
// A value passes bit-serially through a row of VALUE_BITS digit cells, each
// working behind its neighbor through a register, and a registered flag then
// marks completion. Leading zero slots are then dropped at one per cycle and
// the top digit is found; the digits then leave at one per cycle while
// rsp_ch.ready is high, and the block is ready again once the last is taken.
// The digit output is held while rsp_ch.ready is low; nothing advances until
// the receiver takes it. Synchronous reset returns the block to idle.
// ----------------------------------------------------------------------------
`include "integer_to_radix_digits_macros.svh"

module integer_to_radix_digits
   import i2r_pkg::*;
#(
   parameter int VALUE_BITS = 31
) (
   input  logic     clock,
   input  logic     reset,
   i2r_req_if.sink  req_ch,
   i2r_rsp_if.source rsp_ch
);

   localparam int REM_W = $clog2(VALUE_BITS + 1);
   localparam logic [REM_W-1:0] REM_FULL = REM_W'(VALUE_BITS);
   localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

   state_type        state_ff;
   state_type        state_in;
   logic [REM_W-1:0] rem_ff;
   logic [REM_W-1:0] rem_in;
   ctl_type          ctl;
   sts_type          sts;

   i2r_conv #(
      .VALUE_BITS (VALUE_BITS)
   ) u_conv (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .value (req_ch.value),
      .radix (req_ch.radix),
      .sts   (sts)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign rsp_ch.valid = (state_ff == ST_EMIT);
   assign rsp_ch.digit = sts.top;
   assign rsp_ch.last  = (rem_ff == REM_ONE);

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      ctl.start = 1'b0;
      ctl.shift = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               ctl.start = 1'b1;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            if (sts.done) begin
               rem_in   = REM_FULL;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if ((sts.top == '0) && (rem_ff != REM_ONE)) begin
               ctl.shift = 1'b1;
               rem_in    = rem_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ch.ready) begin
               if (rem_ff == REM_ONE) begin
                  state_in = ST_IDLE;
               end else begin
                  ctl.shift = 1'b1;
                  rem_in    = rem_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         rem_ff   <= rem_in;
      end
   end

   `I2R_ASSERT_IMPLY(a_digit_range, rsp_ch.valid, rsp_ch.digit < RADIX_MAX)
   `I2R_ASSERT_NEXT(a_busy_after_req, req_ch.valid && req_ch.ready, !req_ch.ready)
   `I2R_ASSERT_NEXT(a_idle_after_last, rsp_ch.valid && rsp_ch.ready && rsp_ch.last, req_ch.ready)
   `I2R_ASSERT_IMPLY(a_no_lead_zero, (state_ff == ST_SKIP) && (state_in == ST_EMIT) && (rem_ff != REM_ONE), sts.top != '0)

endmodule

@@ test/radix_digit_checker.sv @@
// ----------------------------------------------------------------------------
// radix_digit_checker
// Watches the value and digit channels of the radix converter. Works out the
// digit string for each accepted value and matches returned digits in order.
// ----------------------------------------------------------------------------
module radix_digit_checker
   import i2r_pkg::*;
(
   input  logic clock,
   input  logic reset,
   i2r_req_if   req_ch,
   i2r_rsp_if   rsp_ch,
   output int   fail_count,
   output int   digits_outstanding,
   output int   values_taken,
   output int   digits_taken
);

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } digit_rec_type;

   digit_rec_type digits_due[$];

   // Split a value into digits of the saturated base, most significant first.
   function automatic void queue_digits(input longint unsigned value,
                                        input logic [RADIX_W-1:0] code);
      longint unsigned     base;
      longint unsigned     rest;
      logic [DIGIT_W-1:0]  lsd_first[$];
      base = 64'(code);
      if (code < RADIX_MIN) begin
         base = 64'(RADIX_MIN);
      end else if (code > RADIX_MAX) begin
         base = 64'(RADIX_MAX);
      end
      rest = value;
      do begin
         lsd_first.push_back(DIGIT_W'(rest % base));
         rest = rest / base;
      end while (rest != 0);
      for (int k = lsd_first.size() - 1; k >= 0; k--) begin
         digits_due.push_back('{digit: lsd_first[k], last: (k == 0)});
      end
   endfunction

   always @(posedge clock) begin
      digit_rec_type want;
      if (reset) begin
         digits_due.delete();
         fail_count   = 0;
         values_taken = 0;
         digits_taken = 0;
      end else begin
         // Match digits before queuing a new value taken on the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            digits_taken++;
            if (digits_due.size() == 0) begin
               fail_count++;
               $display("%0t unexpected digit: expected none, got digit %0d last %0b",
                        $time, rsp_ch.digit, rsp_ch.last);
            end else begin
               want = digits_due.pop_front();
               if (rsp_ch.digit !== want.digit || rsp_ch.last !== want.last) begin
                  fail_count++;
                  $display("%0t digit mismatch: expected digit %0d last %0b, got digit %0d last %0b",
                           $time, want.digit, want.last, rsp_ch.digit, rsp_ch.last);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            values_taken++;
            queue_digits(longint'(req_ch.value), req_ch.radix);
         end
      end
      digits_outstanding = digits_due.size();
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives values and radix codes into the radix digit converter with bursty
// traffic and a stalling receiver; the checker scores every digit returned.
// ----------------------------------------------------------------------------
module tb_top
   import i2r_pkg::*;
;

   localparam int VALUE_BITS    = 31;
   localparam int RANDOM_VALUES = 480;
   localparam int QUIET_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 200;

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic rsp_take = 1'b0;
   logic req_fire = 1'b0;
   int   quiet_cycles = 0;
   int   stall_mode   = 0;
   int   mode_left    = 0;
   int   fail_count;
   int   digits_outstanding;
   int   values_taken;
   int   digits_taken;

   i2r_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   i2r_rsp_if rsp_ch ();

   assign rsp_ch.ready = rsp_take;

   integer_to_radix_digits #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   radix_digit_checker chk (
      .clock              (clock),
      .reset              (reset),
      .req_ch             (req_ch),
      .rsp_ch             (rsp_ch),
      .fail_count         (fail_count),
      .digits_outstanding (digits_outstanding),
      .values_taken       (values_taken),
      .digits_taken       (digits_taken)
   );

   always #1 clock = ~clock;

   // Register handshakes for the stimulus side and count quiet cycles.
   always @(posedge clock) begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: switch between always ready, light, heavy and alternating stalls.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 150);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: begin
            rsp_take <= 1'b1;
         end
         1: begin
            rsp_take <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_take <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_take <= ~rsp_take;
         end
      endcase
   end

   // Present one value and hold it until the block takes it.
   task automatic offer(input logic [VALUE_BITS-1:0] value, input logic [RADIX_W-1:0] code);
      req_ch.valid = 1'b1;
      req_ch.value = value;
      req_ch.radix = code;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic pause(input int cycles);
      req_ch.valid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic settle();
      pause(1);
      while (digits_outstanding != 0) @(negedge clock);
   endtask

   // Values of random magnitude, so short and long digit strings both occur.
   function automatic logic [VALUE_BITS-1:0] random_value();
      int          span;
      logic [31:0] raw;
      logic [31:0] mask;
      span = $urandom_range(0, VALUE_BITS);
      raw  = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         raw = '1;
      end
      mask = (span == 0) ? '0 : (32'hFFFF_FFFF >> (32 - span));
      return raw[VALUE_BITS-1:0] & mask[VALUE_BITS-1:0];
   endfunction

   function automatic logic [RADIX_W-1:0] random_radix();
      if ($urandom_range(0, 9) == 0) begin
         return RADIX_W'($urandom_range(0, 15));
      end
      return RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
   endfunction

   initial begin
      int sent;
      int burst;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.radix = RADIX_MIN;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // Zero in every base, extremes, exact powers and out-of-range radix codes.
      for (int r = RADIX_MIN; r <= RADIX_MAX; r++) begin
         offer('0, RADIX_W'(r));
      end
      offer('1, RADIX_MIN);
      offer('1, 4'd3);
      offer('1, RADIX_MAX);
      offer(VALUE_BITS'(1), 4'd7);
      offer(VALUE_BITS'(8), 4'd8);
      offer(VALUE_BITS'(80), 4'd9);
      pause(3);
      offer(VALUE_BITS'(9), RADIX_MAX);
      offer(VALUE_BITS'(10), RADIX_MAX);
      offer(31'h4000_0000, RADIX_MIN);
      offer(31'h2AAA_AAAA, 4'd3);
      offer(VALUE_BITS'(5), 4'd0);
      offer('1, 4'd1);
      offer(VALUE_BITS'(12345), 4'd11);
      offer(VALUE_BITS'(999), 4'd15);
      settle();

      sent = 0;
      while (sent < RANDOM_VALUES) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent < RANDOM_VALUES; i++) begin
            // Hold off once midway until every digit has drained.
            if (sent == RANDOM_VALUES / 2) begin
               settle();
            end
            offer(random_value(), random_radix());
            sent++;
         end
         pause($urandom_range(0, 6));
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d values and %0d digits across radix codes 0 to 15,",
               values_taken, digits_taken);
      $display("with zero, full-width values, bursty input and stalled output");
      if (fail_count == 0 && digits_outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
